// ----- rtl/tsd_pkg.sv -----
`default_nettype none
package tsd_pkg;

	localparam logic [15:0] ONE_Q15 = 16'h8000;

	localparam logic [1:0] CFG_LEFT_DZ  = 2'd0;
	localparam logic [1:0] CFG_RIGHT_DZ = 2'd1;

	typedef struct packed {
		logic [15:0] q;
		logic [63:0] p;
		logic [47:0] r;
	} lane_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] x2;
		logic [31:0] y2;
		logic [31:0] sp2;
		logic        x_neg;
		logic        y_neg;
		logic        outside;
		logic        clamp;
	} ctx_t;

	// One bit of a largest-q search for f(q) <= rhs, where f(q) = q*q*inc + ...
	// p holds f(q) and r holds q*inc plus any linear offset, both kept up to date
	// by shifts and adds only.
	function automatic lane_t search_step(lane_t ln, logic [31:0] inc, logic [63:0] rhs,
			int b);
		logic [15:0] cand;
		logic [63:0] pc;
		logic [47:0] rc;
		lane_t       res;
		cand = ln.q | 16'(1 << b);
		pc   = ln.p + (64'(ln.r) << (b + 1)) + (64'(inc) << (2 * b));
		rc   = ln.r + 48'(64'(inc) << b);
		res  = ln;
		if (cand <= ONE_Q15 && pc <= rhs) begin
			res.q = cand;
			res.p = pc;
			res.r = rc;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tsd_cell.sv -----
`default_nettype none
module tsd_cell #(
	parameter int BIT = 15
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_in,
	input  wire tsd_pkg::ctx_t ctx_in,
	input  wire tsd_pkg::lane_t lx_in,
	input  wire tsd_pkg::lane_t ly_in,
	input  wire tsd_pkg::lane_t ln_in,
	output logic               valid_out,
	output tsd_pkg::ctx_t      ctx_out,
	output tsd_pkg::lane_t     lx_out,
	output tsd_pkg::lane_t     ly_out,
	output tsd_pkg::lane_t     ln_out
);

	logic           valid_q;
	tsd_pkg::ctx_t  ctx_q;
	tsd_pkg::lane_t lx_q, ly_q, ln_q;
	logic [63:0]    rhs_x, rhs_y, rhs_n;

	assign rhs_x = 64'(ctx_in.x2) << 30;
	assign rhs_y = 64'(ctx_in.y2) << 30;
	assign rhs_n = 64'(ctx_in.s) << 30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_in;
			lx_q  <= tsd_pkg::search_step(lx_in, ctx_in.s, rhs_x, BIT);
			ly_q  <= tsd_pkg::search_step(ly_in, ctx_in.s, rhs_y, BIT);
			ln_q  <= tsd_pkg::search_step(ln_in, ctx_in.sp2, rhs_n, BIT);
		end
	end

	assign valid_out = valid_q;
	assign ctx_out   = ctx_q;
	assign lx_out    = lx_q;
	assign ly_out    = ly_q;
	assign ln_out    = ln_q;

endmodule
`default_nettype wire

// ----- rtl/thumbstick_radial_deadzone.sv -----
// Circular dead zone and direction normalisation for a thumbstick sample.
// Input stream: s_tdata carries x_axis and y_axis, s_tuser the stick select.
// Output stream: m_tdata carries norm_magnitude, dir_x and dir_y, m_tuser
// the in_deadzone flag. Configuration writes on cfg_* set the two dead zone
// radii and are always taken.
// One sample is taken per cycle while s_tready is high. A sample passes two
// set-up stages (squares and products, then the squared radius), then a row of
// 16 cells that each settle one result bit of the three square-root searches,
// and then reaches the output register.
// Reset clears all valid flags and loads the reset dead zone radii.
// When the receiver stalls, a one-entry skid buffer behind the output
// register takes the sample in flight; once it is full the whole row holds
// and s_tready falls until the output transfer completes.
`default_nettype none
module thumbstick_radial_deadzone #(
	parameter int AXIS_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // x_axis[15:0], y_axis[31:16]
	input  wire logic        s_tuser,   // stick_select
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // norm_magnitude[15:0], dir_x[32:16], dir_y[49:33]
	output logic             m_tuser,   // in_deadzone
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	localparam logic [15:0] AMAX    = 16'((1 << (AXIS_WIDTH - 1)) - 1);
	localparam logic [31:0] AMAX_SQ = 32'(((1 << (AXIS_WIDTH - 1)) - 1)
		* ((1 << (AXIS_WIDTH - 1)) - 1));
	localparam int NCELL = 16;

	logic [14:0] left_dz_q, right_dz_q;
	logic        en, skid_v_q, out_v_q;
	logic [55:0] skid_data_q, out_data_q, fin_data;
	logic        skid_user_q, out_user_q, fin_user;

	logic signed [AXIS_WIDTH-1:0] xn, yn;
	logic signed [15:0]           xv, yv;
	logic [14:0]                  dz;
	logic [15:0]                  span;

	logic        v_s1;
	logic [31:0] x2_s1, y2_s1, sp2_s1, dzsp_s1;
	logic [29:0] dz2_s1;
	logic [14:0] dz_s1;
	logic        x_neg_s1, y_neg_s1;

	logic           v_s2;
	tsd_pkg::ctx_t  ctx_s2;
	tsd_pkg::lane_t lx_s2, ly_s2, ln_s2;
	logic [31:0]    s_sum;

	logic           v_c   [0:NCELL];
	tsd_pkg::ctx_t  ctx_c [0:NCELL];
	tsd_pkg::lane_t lx_c  [0:NCELL];
	tsd_pkg::lane_t ly_c  [0:NCELL];
	tsd_pkg::lane_t ln_c  [0:NCELL];

	logic [15:0] norm;
	logic [16:0] dx, dy;
	logic        fin_v, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_dz_q  <= 15'd7849;
			right_dz_q <= 15'd8689;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsd_pkg::CFG_LEFT_DZ:  left_dz_q  <= cfg_data;
				tsd_pkg::CFG_RIGHT_DZ: right_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_v_q;
	assign s_tready = en;

	assign xn   = s_tdata[AXIS_WIDTH-1:0];
	assign yn   = s_tdata[16+AXIS_WIDTH-1:16];
	assign xv   = 16'(xn);
	assign yv   = 16'(yn);
	assign dz   = s_tuser ? right_dz_q : left_dz_q;
	assign span = AMAX - {1'b0, dz};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s1    <= 32'(xv) * 32'(xv);
			y2_s1    <= 32'(yv) * 32'(yv);
			dz2_s1   <= dz * dz;
			dzsp_s1  <= 32'(dz) * 32'(span);
			sp2_s1   <= span * span;
			dz_s1    <= dz;
			x_neg_s1 <= xv[15];
			y_neg_s1 <= yv[15];
		end
	end

	assign s_sum = x2_s1 + y2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2.s       <= s_sum;
			ctx_s2.x2      <= x2_s1;
			ctx_s2.y2      <= y2_s1;
			ctx_s2.sp2     <= sp2_s1;
			ctx_s2.x_neg   <= x_neg_s1;
			ctx_s2.y_neg   <= y_neg_s1;
			ctx_s2.outside <= s_sum > 32'(dz2_s1);
			ctx_s2.clamp   <= ({1'b0, dz_s1} >= AMAX) || (s_sum >= AMAX_SQ);
			lx_s2          <= '0;
			ly_s2          <= '0;
			ln_s2.q        <= '0;
			ln_s2.p        <= 64'(dz2_s1) << 30;
			ln_s2.r        <= 48'(64'(dzsp_s1) << 15);
		end
	end

	assign v_c[0]   = v_s2;
	assign ctx_c[0] = ctx_s2;
	assign lx_c[0]  = lx_s2;
	assign ly_c[0]  = ly_s2;
	assign ln_c[0]  = ln_s2;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		tsd_cell #(.BIT(NCELL - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (v_c[i]),
			.ctx_in   (ctx_c[i]),
			.lx_in    (lx_c[i]),
			.ly_in    (ly_c[i]),
			.ln_in    (ln_c[i]),
			.valid_out(v_c[i+1]),
			.ctx_out  (ctx_c[i+1]),
			.lx_out   (lx_c[i+1]),
			.ly_out   (ly_c[i+1]),
			.ln_out   (ln_c[i+1])
		);
	end

	always_comb begin
		norm = '0;
		if (ctx_c[NCELL].outside) begin
			norm = ctx_c[NCELL].clamp ? tsd_pkg::ONE_Q15 : ln_c[NCELL].q;
		end
		dx = '0;
		dy = '0;
		if (ctx_c[NCELL].s != '0) begin
			dx = ctx_c[NCELL].x_neg ? 17'(-{1'b0, lx_c[NCELL].q}) : {1'b0, lx_c[NCELL].q};
			dy = ctx_c[NCELL].y_neg ? 17'(-{1'b0, ly_c[NCELL].q}) : {1'b0, ly_c[NCELL].q};
		end
	end

	assign fin_data = {6'b0, dy, dx, norm};
	assign fin_user = !ctx_c[NCELL].outside;
	assign fin_v    = en && v_c[NCELL];
	assign pop      = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fin_v;
			end
		end else if (fin_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_data_q <= skid_v_q ? skid_data_q : fin_data;
			out_user_q <= skid_v_q ? skid_user_q : fin_user;
		end else if (fin_v) begin
			skid_data_q <= fin_data;
			skid_user_q <= fin_user;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid buffer holds a sample while the output register is empty");

	a_dz_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'd0))
		else $error("magnitude is not zero inside the dead zone");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= tsd_pkg::ONE_Q15))
		else $error("magnitude above full deflection");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_tready) |=> skid_v_q)
		else $error("skid buffer lost a sample during a stall");

endmodule
`default_nettype wire

// ----- verif/thumbstick_radial_deadzone_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module thumbstick_radial_deadzone_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	output int               errors,
	output int               pending
);

	localparam longint unsigned AXIS_MAX = 32767;

	typedef struct packed {
		logic [15:0] magnitude;
		logic [16:0] dir_x;
		logic [16:0] dir_y;
		logic        in_zone;
	} stick_result_t;

	stick_result_t expected_results[$];
	logic [14:0] left_dz, right_dz;

	// Largest q in 0..32768 with q*q*s <= a*a*2^30, negated for negative v; zero when s is zero.
	function automatic logic [16:0] direction_q15(longint signed v, longint unsigned s);
		longint unsigned a, lo, hi, mid, rhs;
		if (s == 0)
			return 17'd0;
		a = (v < 0) ? -v : v;
		rhs = (a * a) << 30;
		lo = 0;
		hi = 32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid * s <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (v < 0) ? 17'(18'h20000 - lo) : 17'(lo);
	endfunction

	function automatic stick_result_t deadzone_result(logic sel, logic [31:0] data);
		longint signed x, y;
		longint unsigned s, dz, span, base, rhs, lo, hi, mid, t;
		stick_result_t res;
		x = longint'($signed(data[15:0]));
		y = longint'($signed(data[31:16]));
		dz = sel ? right_dz : left_dz;
		s = x * x + y * y;
		res.in_zone = !(s > dz * dz);
		res.magnitude = 16'd0;
		if (!res.in_zone) begin
			if (dz >= AXIS_MAX || s >= AXIS_MAX * AXIS_MAX) begin
				res.magnitude = tsd_pkg::ONE_Q15;
			end else begin
				span = AXIS_MAX - dz;
				base = 32768 * dz;
				rhs = s << 30;
				lo = 0;
				hi = 32768;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					t = mid * span + base;
					if (t * t <= rhs)
						lo = mid;
					else
						hi = mid - 1;
				end
				res.magnitude = 16'(lo);
			end
		end
		res.dir_x = direction_q15(x, s);
		res.dir_y = direction_q15(y, s);
		return res;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		stick_result_t e;
		int            bad;
		bad = 0;
		if (!arst_n) begin
			left_dz <= 15'd7849;
			right_dz <= 15'd8689;
			errors <= 0;
			expected_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tsd_pkg::CFG_LEFT_DZ)
					left_dz <= cfg_data;
				else if (cfg_index == tsd_pkg::CFG_RIGHT_DZ)
					right_dz <= cfg_data;
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(deadzone_result(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					bad++;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[15:0] !== e.magnitude) begin
						$error("norm_magnitude: expected %0d, got %0d", e.magnitude,
							m_tdata[15:0]);
						bad++;
					end
					if (m_tdata[32:16] !== e.dir_x) begin
						$error("dir_x: expected %h, got %h", e.dir_x, m_tdata[32:16]);
						bad++;
					end
					if (m_tdata[49:33] !== e.dir_y) begin
						$error("dir_y: expected %h, got %h", e.dir_y, m_tdata[49:33]);
						bad++;
					end
					if (m_tuser !== e.in_zone) begin
						$error("in_deadzone: expected %b, got %b", e.in_zone, m_tuser);
						bad++;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end
endmodule
`default_nettype wire

// ----- verif/thumbstick_radial_deadzone_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module thumbstick_radial_deadzone_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;
	int          errors;
	int          pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	thumbstick_radial_deadzone dut (.*);

	thumbstick_radial_deadzone_checker checker_inst (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("thumbstick_radial_deadzone_test: done, errors");
		$finish;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	task automatic write_deadzone(logic [1:0] idx, logic [14:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(logic sel, logic signed [15:0] x, logic signed [15:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= sel;
		s_tdata <= {y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Equal shares of vectors anywhere, within +-10000, within +-32 and at full-scale x.
	task automatic random_samples(int n);
		logic signed [15:0] x, y;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
				1: begin
					x = 16'($signed($urandom_range(20000)) - 10000);
					y = 16'($signed($urandom_range(20000)) - 10000);
				end
				2: begin
					x = 16'($signed($urandom_range(64)) - 32);
					y = 16'($signed($urandom_range(64)) - 32);
				end
				default: begin
					x = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
					y = 16'($urandom);
				end
			endcase
			send_sample(1'($urandom), x, y);
		end
	endtask

	initial begin
		logic signed [15:0] corner[6] = '{16'sh0, 16'sh1, -16'sh1, 16'sh7fff,
			16'sh8000, 16'sh1ea9};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_sample(i[0], corner[i], corner[5 - i]);
		send_sample(1'b0, 16'sd7849, 16'sd0);
		send_sample(1'b0, 16'sd7850, 16'sd0);
		send_sample(1'b1, 16'sd0, -16'sd8689);
		send_sample(1'b1, 16'sd0, -16'sd8690);
		send_sample(1'b0, 16'sh8000, 16'sh8000);
		send_sample(1'b1, 16'sh7fff, 16'sh7fff);
		send_sample(1'b0, 16'sd23170, 16'sd23170);
		drain();
		write_deadzone(tsd_pkg::CFG_LEFT_DZ, 15'd0);
		write_deadzone(tsd_pkg::CFG_RIGHT_DZ, 15'd32766);
		send_sample(1'b0, 16'sd0, 16'sd0);
		send_sample(1'b0, 16'sd1, 16'sd0);
		send_sample(1'b1, 16'sd32766, 16'sd0);
		send_sample(1'b1, 16'sd32767, 16'sd0);
		send_sample(1'b1, 16'sh8000, 16'sd1);
		random_samples(100);
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			write_deadzone(tsd_pkg::CFG_LEFT_DZ, 15'($urandom_range(32766)));
			write_deadzone(tsd_pkg::CFG_RIGHT_DZ, 15'($urandom_range(12000)));
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 30 : 88) : 0;
			stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 30 : 88) : 0;
			random_samples(450);
			drain();
		end
		write_deadzone(tsd_pkg::CFG_LEFT_DZ, 15'd7849);
		write_deadzone(tsd_pkg::CFG_RIGHT_DZ, 15'd8689);
		random_samples(100);
		drain();
		if (errors == 0)
			$display("thumbstick_radial_deadzone_test: done, clean");
		else
			$display("thumbstick_radial_deadzone_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
